/* sv/gmx_pkg.sv */
// ----------------------------------------------------------------------------
// gmx_pkg
// Shared widths, constants and types for the saturating gain mixer.
// ----------------------------------------------------------------------------
package gmx_pkg;

	localparam int MAX_CH     = 8;
	localparam int SAMPLE_W   = 16;
	localparam int GAIN_W     = 16;
	localparam int MASK_W     = 8;
	localparam int PROD_W     = 32;
	localparam int FRAC_BITS  = 12;
	localparam int CONTRIB_W  = 20;
	localparam int PAIR_W     = CONTRIB_W + 1;
	localparam int QUAD_W     = CONTRIB_W + 2;
	localparam int SUM_W      = CONTRIB_W + 3;
	localparam int CFG_ADDR_W = 4;
	localparam int IN_DATA_W  = MAX_CH * SAMPLE_W;

	localparam int DEF_NUM_CHANNELS = 8;

	localparam logic signed [GAIN_W-1:0] UNITY_GAIN = 16'sd4096;
	localparam logic signed [SUM_W-1:0]  SAT_HIGH   = 23'sd32767;
	localparam logic signed [SUM_W-1:0]  SAT_LOW    = -23'sd32767;

	typedef struct packed {
		logic en;
		logic present;
	} lane_ctrl_t;

endpackage

/* sv/gmx_lane.sv */
// ----------------------------------------------------------------------------
// gmx_lane
// One channel: gain multiply, then divide by unity gain truncating toward zero.
// ----------------------------------------------------------------------------
module gmx_lane (
	input  logic                                     clk,
	input  gmx_pkg::lane_ctrl_t                      ctrl,
	input  logic signed [gmx_pkg::SAMPLE_W-1:0]      sample,
	input  logic signed [gmx_pkg::GAIN_W-1:0]        gain,
	output logic signed [gmx_pkg::CONTRIB_W-1:0]     contrib_s3
);

	logic signed [gmx_pkg::PROD_W-1:0] prod_d;
	logic signed [gmx_pkg::PROD_W-1:0] prod_s2;
	logic signed [gmx_pkg::PROD_W-1:0] biased;

	assign prod_d = sample * gain;

	// negative products get a bias so the shift rounds toward zero
	assign biased = prod_s2 + (prod_s2[gmx_pkg::PROD_W-1] ?
		gmx_pkg::PROD_W'((1 << gmx_pkg::FRAC_BITS) - 1) : gmx_pkg::PROD_W'(0));

	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			prod_s2    <= ctrl.present ? prod_d : '0;
			contrib_s3 <= biased[gmx_pkg::FRAC_BITS + gmx_pkg::CONTRIB_W - 1:gmx_pkg::FRAC_BITS];
		end
	end

endmodule

/* sv/gain_mixer_saturating.sv */
// ----------------------------------------------------------------------------
// gain_mixer_saturating
// Eight-channel mix-down with per-channel Q3.12 gain and output saturation.
// ----------------------------------------------------------------------------
// One frame (eight samples plus presence mask in tuser) is taken per clock
// while s_tready is high, and one mixed sample leaves per frame, in order.
// The pipeline is input register, lane multiply, lane scaling, pair sums, quad
// sums, then final add and clamp into the output register; the whole pipeline
// holds while the output beat waits, so s_tready is !m_tvalid || m_tready. Gains are
// written through cfg_we/cfg_addr/cfg_wdata and reset to unity (4096).
module gain_mixer_saturating #(
	parameter int NUM_CHANNELS = gmx_pkg::DEF_NUM_CHANNELS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// sample_ch0 .. sample_ch7, 16 bits each, ch0 lowest
	input  logic [gmx_pkg::IN_DATA_W-1:0]     s_tdata,
	// present_mask
	input  logic [gmx_pkg::MASK_W-1:0]        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// mixed_sample
	output logic [gmx_pkg::SAMPLE_W-1:0]      m_tdata,
	input  logic                              cfg_we,
	input  logic [gmx_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [gmx_pkg::GAIN_W-1:0]        cfg_wdata
);

	logic en;
	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic m_tvalid_q;

	logic [gmx_pkg::IN_DATA_W-1:0]  samples_s1;
	logic [gmx_pkg::MASK_W-1:0]     mask_s1;

	logic signed [gmx_pkg::GAIN_W-1:0]    gain_q [NUM_CHANNELS];
	logic signed [gmx_pkg::CONTRIB_W-1:0] contrib_s3 [gmx_pkg::MAX_CH];
	logic signed [gmx_pkg::PAIR_W-1:0]    pair_s4 [gmx_pkg::MAX_CH/2];
	logic signed [gmx_pkg::QUAD_W-1:0]    quad_s5 [gmx_pkg::MAX_CH/4];
	logic signed [gmx_pkg::SUM_W-1:0]     sum_d;
	logic signed [gmx_pkg::SAMPLE_W-1:0]  mix_d;
	logic [gmx_pkg::SAMPLE_W-1:0]         m_tdata_q;

	assign en       = !m_tvalid_q || m_tready;
	assign s_tready = en;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			v_s2       <= 1'b0;
			v_s3       <= 1'b0;
			v_s4       <= 1'b0;
			v_s5       <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else if (en) begin
			v_s1       <= s_tvalid;
			v_s2       <= v_s1;
			v_s3       <= v_s2;
			v_s4       <= v_s3;
			v_s5       <= v_s4;
			m_tvalid_q <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			samples_s1 <= s_tdata;
			mask_s1    <= s_tuser;
		end
	end

	for (genvar i = 0; i < gmx_pkg::MAX_CH; i++) begin : g_lane
		if (i < NUM_CHANNELS) begin : g_on
			gmx_pkg::lane_ctrl_t ctrl;

			assign ctrl.en      = en;
			assign ctrl.present = mask_s1[i];

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					gain_q[i] <= gmx_pkg::UNITY_GAIN;
				end else if (cfg_we && cfg_addr == gmx_pkg::CFG_ADDR_W'(i)) begin
					gain_q[i] <= cfg_wdata;
				end
			end

			gmx_lane u_lane (
				.clk        (clk),
				.ctrl       (ctrl),
				.sample     (samples_s1[i*gmx_pkg::SAMPLE_W +: gmx_pkg::SAMPLE_W]),
				.gain       (gain_q[i]),
				.contrib_s3 (contrib_s3[i])
			);
		end else begin : g_off
			assign contrib_s3[i] = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < gmx_pkg::MAX_CH/2; k++) begin
				pair_s4[k] <= gmx_pkg::PAIR_W'(contrib_s3[2*k])
					+ gmx_pkg::PAIR_W'(contrib_s3[2*k+1]);
			end
			for (int k = 0; k < gmx_pkg::MAX_CH/4; k++) begin
				quad_s5[k] <= gmx_pkg::QUAD_W'(pair_s4[2*k])
					+ gmx_pkg::QUAD_W'(pair_s4[2*k+1]);
			end
		end
	end

	assign sum_d = gmx_pkg::SUM_W'(quad_s5[0]) + gmx_pkg::SUM_W'(quad_s5[1]);

	always_comb begin
		priority if (sum_d > gmx_pkg::SAT_HIGH) begin
			mix_d = gmx_pkg::SAT_HIGH[gmx_pkg::SAMPLE_W-1:0];
		end else if (sum_d < gmx_pkg::SAT_LOW) begin
			mix_d = gmx_pkg::SAT_LOW[gmx_pkg::SAMPLE_W-1:0];
		end else begin
			mix_d = sum_d[gmx_pkg::SAMPLE_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_tdata_q <= mix_d;
		end
	end

	// clamp keeps the most negative code off the bus
	a_no_min_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata != 16'h8000)
		else $error("mixed sample hit -32768");

	a_ready_rule: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output state");

	a_last_stage: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s5) |=> m_tvalid)
		else $error("stage five beat lost");

	a_zero_mix: assert property (@(posedge clk) disable iff (!arst_n)
		(en && v_s5 && quad_s5[0] == '0 && quad_s5[1] == '0) |=> m_tdata == '0)
		else $error("zero sum not passed as zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> ($stable(v_s1) && $stable(v_s5)))
		else $error("pipeline moved during stall");

endmodule

/* sim/gain_mixer_saturating_test.sv */
// ----------------------------------------------------------------------------
// gain_mixer_saturating_test
// Self-checking bench for the eight-channel saturating gain mixer. A directed
// table covers reset gains, sample and gain extremes, empty and full masks,
// truncation toward zero and ignored register indexes. Random frames follow
// under several gain settings. Each output beat is checked against an
// in-bench mix predictor, with random idle bursts on both stream sides.
// ----------------------------------------------------------------------------
module gain_mixer_saturating_test;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int MIX_MAX        = 32767;
	localparam int MIX_MIN        = -32767;
	localparam int RAND_PHASES    = 6;
	localparam int PHASE_FRAMES   = 125;
	localparam int QUIET_FROM     = RAND_PHASES * PHASE_FRAMES - 100;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_PAUSE    = 8;

	// gain setting selectors for the directed table
	localparam logic [2:0] GS_UNITY   = 3'd0;
	localparam logic [2:0] GS_MAX     = 3'd1;
	localparam logic [2:0] GS_MIN     = 3'd2;
	localparam logic [2:0] GS_MIXED   = 3'd3;
	localparam logic [2:0] GS_BAD_IDX = 3'd4;

	typedef struct packed {
		logic [2:0]                    gset;
		logic [gmx_pkg::IN_DATA_W-1:0] data;
		logic [gmx_pkg::MASK_W-1:0]    mask;
		logic                          has_exp;
		logic [gmx_pkg::SAMPLE_W-1:0]  exp_val;
	} frame_row_t;

	typedef struct packed {
		logic [31:0]                  idx;
		logic [gmx_pkg::SAMPLE_W-1:0] val;
	} mix_exp_t;

	logic                           clk = 1'b0;
	logic                           arst_n = 1'b0;
	logic                           s_tvalid = 1'b0;
	logic                           s_tready;
	logic [gmx_pkg::IN_DATA_W-1:0]  s_tdata = '0;
	logic [gmx_pkg::MASK_W-1:0]     s_tuser = '0;
	logic                           m_tvalid;
	logic                           m_tready = 1'b0;
	logic [gmx_pkg::SAMPLE_W-1:0]   m_tdata;
	logic                           cfg_we = 1'b0;
	logic [gmx_pkg::CFG_ADDR_W-1:0] cfg_addr = '0;
	logic [gmx_pkg::GAIN_W-1:0]     cfg_wdata = '0;

	logic signed [gmx_pkg::GAIN_W-1:0] gain_model [gmx_pkg::MAX_CH];
	logic [gmx_pkg::GAIN_W-1:0]        gain_sets [4][gmx_pkg::MAX_CH];
	frame_row_t                        frame_tab [$];
	mix_exp_t                          mix_expect_q [$];
	int                                frame_count = 0;
	int                                mismatches = 0;
	int                                idle_cycles = 0;
	int                                stall_left = 0;
	bit                                quiet = 1'b0;

	gain_mixer_saturating dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_addr (cfg_addr),
		.cfg_wdata(cfg_wdata)
	);

	always #5 clk = ~clk;

	function automatic logic [gmx_pkg::SAMPLE_W-1:0] predict_mix(
			input logic [gmx_pkg::IN_DATA_W-1:0] data,
			input logic [gmx_pkg::MASK_W-1:0] mask);
		int acc;
		int g;
		int v;
		acc = 0;
		for (int ch = 0; ch < gmx_pkg::MAX_CH; ch++) begin
			if (mask[ch]) begin
				g = gain_model[ch];
				v = $signed(data[ch*gmx_pkg::SAMPLE_W +: gmx_pkg::SAMPLE_W]);
				acc += (g * v) / (1 << gmx_pkg::FRAC_BITS);
			end
		end
		if (acc > MIX_MAX)
			acc = MIX_MAX;
		else if (acc < MIX_MIN)
			acc = MIX_MIN;
		return acc[gmx_pkg::SAMPLE_W-1:0];
	endfunction

	function automatic logic [gmx_pkg::IN_DATA_W-1:0] one_chan(input int ch,
			input logic [15:0] v);
		logic [gmx_pkg::IN_DATA_W-1:0] d;
		d = '0;
		d[ch*gmx_pkg::SAMPLE_W +: gmx_pkg::SAMPLE_W] = v;
		return d;
	endfunction

	function automatic void add_row(input logic [2:0] gset,
			input logic [gmx_pkg::IN_DATA_W-1:0] data,
			input logic [gmx_pkg::MASK_W-1:0] mask, input logic has_exp,
			input logic [15:0] exp_val);
		frame_row_t r;
		r.gset = gset;
		r.data = data;
		r.mask = mask;
		r.has_exp = has_exp;
		r.exp_val = exp_val;
		frame_tab.push_back(r);
	endfunction

	function automatic logic [gmx_pkg::SAMPLE_W-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'($urandom_range(0, 15));
			3: return 16'(-$urandom_range(1, 16));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [gmx_pkg::GAIN_W-1:0] rand_gain();
		case ($urandom_range(0, 9))
			0: return 16'h7fff;
			1: return 16'h8000;
			2: return 16'h0000;
			3: return 16'h1000;
			4: return 16'hf000;
			5: return 16'h0001;
			6: return 16'hffff;
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic logic [gmx_pkg::MASK_W-1:0] rand_mask();
		case ($urandom_range(0, 7))
			0: return 8'h00;
			1: return 8'hff;
			2: return 8'(1 << $urandom_range(0, 7));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic report_mismatch(input string what, input int idx, input logic [15:0] exp_val,
			input logic [15:0] act_val);
		mismatches++;
		if (mismatches <= 10)
			$display("MISMATCH %s frame %0d: expected %0d (%h) got %0d (%h)", what, idx,
				$signed(exp_val), exp_val, $signed(act_val), act_val);
	endtask

	// all tasks below start and end just after a falling edge
	task automatic send_frame(input logic [gmx_pkg::IN_DATA_W-1:0] data,
			input logic [gmx_pkg::MASK_W-1:0] mask,
			input logic has_exp, input logic [15:0] exp_val);
		int gap;
		mix_exp_t e;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 4);
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= data;
		s_tuser <= mask;
		do @(posedge clk); while (!s_tready);
		e.idx = frame_count;
		e.val = has_exp ? exp_val : predict_mix(data, mask);
		mix_expect_q.push_back(e);
		frame_count++;
		@(negedge clk);
	endtask

	task automatic halt_and_drain();
		s_tvalid <= 1'b0;
		while (mix_expect_q.size() != 0) @(negedge clk);
		repeat (DRAIN_PAUSE) @(negedge clk);
	endtask

	task automatic write_gain(input int addr, input logic [gmx_pkg::GAIN_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_addr <= gmx_pkg::CFG_ADDR_W'(addr);
		cfg_wdata <= val;
		if (addr < gmx_pkg::MAX_CH)
			gain_model[addr] = val;
		@(negedge clk);
	endtask

	task automatic write_bad_indexes(input int count);
		for (int k = 0; k < count; k++)
			write_gain(gmx_pkg::MAX_CH
				+ (count == gmx_pkg::MAX_CH ? k : $urandom_range(0, gmx_pkg::MAX_CH - 1)),
				16'($urandom));
	endtask

	// beats toward the bench
	always @(posedge clk) begin : mix_check
		mix_exp_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (mix_expect_q.size() == 0) begin
				report_mismatch("unexpected beat", -1, 'x, m_tdata);
			end else begin
				e = mix_expect_q.pop_front();
				if (m_tdata !== e.val)
					report_mismatch("mixed_sample", e.idx, e.val, m_tdata);
			end
		end
	end

	always @(negedge clk) begin
		if (quiet) begin
			m_tready <= 1'b1;
		end else if (stall_left > 0) begin
			m_tready <= 1'b0;
			stall_left = stall_left - 1;
		end else if ($urandom_range(0, 5) == 0) begin
			m_tready <= 1'b0;
			stall_left = $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
				idle_cycles <= 0;
			end else begin
				idle_cycles <= idle_cycles + 1;
				if (idle_cycles >= WATCHDOG_LIMIT) begin
					$display("Testbench completed WITH ERRORS");
					$finish;
				end
			end
		end
	end

	initial begin
		logic [2:0] cur_set;
		int sel;

		for (int ch = 0; ch < gmx_pkg::MAX_CH; ch++) begin
			gain_model[ch] = gmx_pkg::UNITY_GAIN;
			gain_sets[GS_UNITY][ch] = 16'h1000;
			gain_sets[GS_MAX][ch] = 16'h7fff;
			gain_sets[GS_MIN][ch] = 16'h8000;
		end
		gain_sets[GS_MIXED] = '{16'h0001, 16'hffff, 16'h0000, 16'h1000,
			16'hf000, 16'h7fff, 16'h8000, 16'h0800};

		// reset gains are unity
		add_row(GS_UNITY, '0, 8'hff, 1'b1, 16'h0000);
		add_row(GS_UNITY, {8{16'h7fff}}, 8'h00, 1'b1, 16'h0000);
		add_row(GS_UNITY, one_chan(0, 16'h7fff), 8'h01, 1'b1, 16'h7fff);
		add_row(GS_UNITY, one_chan(3, 16'h8000), 8'h08, 1'b1, 16'h8001);
		add_row(GS_UNITY, {8{16'h7fff}}, 8'hff, 1'b1, 16'h7fff);
		add_row(GS_UNITY, {8{16'h8000}}, 8'hff, 1'b1, 16'h8001);
		add_row(GS_UNITY, {{16'h1234}, {7{16'h7fff}}}, 8'h80, 1'b1, 16'h1234);
		add_row(GS_UNITY, {4{16'h5a5a, 16'ha5a5}}, 8'h55, 1'b0, '0);
		add_row(GS_MAX, {8{16'hffff}}, 8'hff, 1'b0, '0);
		add_row(GS_MAX, one_chan(0, 16'h7fff), 8'h01, 1'b1, 16'h7fff);
		add_row(GS_MIN, {8{16'h8000}}, 8'hff, 1'b1, 16'h7fff);
		add_row(GS_MIN, one_chan(1, 16'h0001), 8'h02, 1'b0, '0);
		add_row(GS_MIN, {8{16'h7fff}}, 8'hff, 1'b1, 16'h8001);
		add_row(GS_MIXED, {8{16'hffff}}, 8'hff, 1'b0, '0);
		add_row(GS_MIXED, {8{16'h7fff}}, 8'hff, 1'b0, '0);
		add_row(GS_MIXED, {8{16'h8000}}, 8'hff, 1'b0, '0);
		add_row(GS_MIXED, {4{16'h0fff, 16'hf001}}, 8'hff, 1'b0, '0);
		add_row(GS_BAD_IDX, {8{16'h7fff}}, 8'hff, 1'b0, '0);
		add_row(GS_BAD_IDX, one_chan(2, 16'h1000), 8'h04, 1'b0, '0);
		add_row(GS_BAD_IDX, {4{16'h0001, 16'h8000}}, 8'hff, 1'b0, '0);

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		cur_set = GS_UNITY;
		foreach (frame_tab[i]) begin
			if (frame_tab[i].gset != cur_set) begin
				halt_and_drain();
				if (frame_tab[i].gset == GS_BAD_IDX) begin
					write_bad_indexes(gmx_pkg::MAX_CH);
				end else begin
					for (int ch = 0; ch < gmx_pkg::MAX_CH; ch++)
						write_gain(ch, gain_sets[frame_tab[i].gset][ch]);
				end
				cfg_we <= 1'b0;
				cur_set = frame_tab[i].gset;
			end
			send_frame(frame_tab[i].data, frame_tab[i].mask, frame_tab[i].has_exp,
				frame_tab[i].exp_val);
		end

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			halt_and_drain();
			for (int ch = 0; ch < gmx_pkg::MAX_CH; ch++) begin
				case (ph)
					1: write_gain(ch, 16'h7fff);
					2: write_gain(ch, 16'h8000);
					3: write_gain(ch, ch[0] ? 16'h0000 : 16'h1000);
					4: write_gain(ch, 16'($signed($urandom_range(0, 16384)) - 8192));
					default: write_gain(ch, rand_gain());
				endcase
			end
			write_bad_indexes($urandom_range(1, 3));
			cfg_we <= 1'b0;
			for (int n = 0; n < PHASE_FRAMES; n++) begin
				logic [gmx_pkg::IN_DATA_W-1:0] d;
				sel = ph * PHASE_FRAMES + n;
				if (sel >= QUIET_FROM)
					quiet = 1'b1;
				for (int ch = 0; ch < gmx_pkg::MAX_CH; ch++)
					d[ch*gmx_pkg::SAMPLE_W +: gmx_pkg::SAMPLE_W] = rand_sample();
				send_frame(d, rand_mask(), 1'b0, '0);
			end
		end

		s_tvalid <= 1'b0;
		while (mix_expect_q.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
